### hw/rtl/rgbu_pkg.sv
// ----------------------------------------------------------------------------
// rgbu_pkg: shared types and constants of the RGB 2x average upscaler
// Holds the item structs, register indexes, limits and the per-channel
// floor average used on the datapath.
// ----------------------------------------------------------------------------
package rgbu_pkg;

    // Limits and register reset values
    localparam int          RGBU_MAX_WIDTH   = 2048;
    localparam int          RGBU_MAX_HEIGHT  = 4096;
    localparam int          RGBU_WREG_W      = 12;
    localparam int          RGBU_HREG_W      = 13;
    localparam int          RGBU_CFG_DATA_W  = 13;
    localparam int          RGBU_ROW_W       = 12;
    localparam int          RGBU_OUT_ROW_W   = 13;
    localparam int          RGBU_OUT_COL_W   = 12;
    localparam int          RGBU_PIX_W       = 24;
    localparam logic [11:0] RGBU_WIDTH_RST   = 12'd640;
    localparam logic [12:0] RGBU_HEIGHT_RST  = 13'd480;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Source pixel item
    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_pix_in;

    // Result item
    typedef struct packed {
        logic [7:0]                out_blue;
        logic [7:0]                out_green;
        logic [7:0]                out_red;
        logic [RGBU_OUT_ROW_W-1:0] out_row;
        logic [RGBU_OUT_COL_W-1:0] out_col;
        logic                      last_of_run;
    } t_pix_out;

    // Per-channel floor average of two packed pixels (blue in the low byte)
    function automatic logic [RGBU_PIX_W-1:0] avg24(
        input logic [RGBU_PIX_W-1:0] a,
        input logic [RGBU_PIX_W-1:0] b
    );
        logic [RGBU_PIX_W-1:0] r;
        logic [8:0]            s;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
            r[8*k +: 8] = s[8:1];
        end
        return r;
    endfunction

endpackage

### hw/rtl/rgb_2x_average_upscaler_top.sv
// ----------------------------------------------------------------------------
// rgb_2x_average_upscaler_top: 2x average upscaler for raster RGB pixels
// Source pixels stream in raster order; the block emits the enlarged
// (2H-1)x(2W-1) image as tagged output pixels.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data) takes one source
//    pixel per item. Output channel (o_out_valid / i_out_ready / o_out_data)
//    gives 1, 2 or 4 result items per source pixel, each with its row and
//    column in the enlarged image; last_of_run marks the final one.
//  - The previous source row sits in a line buffer RAM, read and written at
//    the same column when the pixel is accepted.
//  - An accepted pixel passes stage 1, stage 2 and the output register.
//  - Throughput: one result per cycle while the receiver takes them; a pixel
//    has 4 results in the body of the image, 2 on the first row or first
//    column, 1 at the top-left corner; the result sequencer sets this.
//  - Configuration (image width and height) is written on the plain write
//    port by the user while the block is idle; the block does not enforce it.
//  - Reset clears counters, held neighbours, the pipeline and the output
//    register; the line buffer needs no clearing, as row 0 ignores its data.
//  - When the receiver stalls, the output register holds its item, the
//    sequencer and the input stage fill up and o_in_ready drops.
// ----------------------------------------------------------------------------
module rgb_2x_average_upscaler_top
    import rgbu_pkg::*;
#(
    parameter int MAX_WIDTH = RGBU_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Source pixels
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_pix_in                    i_in_data,
    // Result pixels
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_pix_out                   o_out_data,
    // Configuration writes
    input  logic                       i_cfg_we,
    input  t_cfg_idx                   i_cfg_idx,
    input  logic [RGBU_CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CW1 = $clog2(MAX_WIDTH + 1);
    localparam int WW  = (CW1 > RGBU_WREG_W) ? CW1 : RGBU_WREG_W;

    // Configuration registers
    logic [RGBU_WREG_W-1:0] r_cfg_width;
    logic [RGBU_HREG_W-1:0] r_cfg_height;

    // Position counters and held neighbours
    logic [CW-1:0]          r_col,  n_col;
    logic [RGBU_ROW_W-1:0]  r_row,  n_row;
    logic [RGBU_PIX_W-1:0]  r_left;
    logic [RGBU_PIX_W-1:0]  r_lva;

    // Stage 1: accepted pixel, waiting for line buffer data
    logic                      r_s1_valid;
    logic [RGBU_PIX_W-1:0]     r_s1_cur;
    logic [RGBU_PIX_W-1:0]     r_s1_left;
    logic [RGBU_OUT_ROW_W-1:0] r_s1_r2;
    logic [RGBU_OUT_COL_W-1:0] r_s1_c2;
    logic                      r_s1_top;
    logic                      r_s1_mid;

    // Stage 2: result slots, drained one per cycle unless the output stalls
    logic [3:0]                r_s2_mask, n_s2_mask;
    logic [RGBU_PIX_W-1:0]     r_s2_px [4];
    logic [RGBU_OUT_ROW_W-1:0] r_s2_r2;
    logic [RGBU_OUT_COL_W-1:0] r_s2_c2;

    // Output register
    logic                      r_out_valid;
    t_pix_out                  r_out;

    // Datapath signals
    logic [WW-1:0]             w_eff;
    logic [WW-1:0]             wreg_ext;
    logic [RGBU_HREG_W-1:0]    h_eff;
    logic                      pre_wrap;
    logic [CW-1:0]             cur_j;
    logic [RGBU_HREG_W-1:0]    row_pre;
    logic [RGBU_ROW_W-1:0]     cur_i;
    logic [WW-1:0]             j_inc;
    logic [RGBU_HREG_W-1:0]    i_inc;
    logic [CW:0]               c2_full;
    logic [RGBU_PIX_W-1:0]     cur_px;
    logic [RGBU_PIX_W-1:0]     ram_rdata;
    logic [RGBU_PIX_W-1:0]     vavg;
    logic                      in_acc;
    logic                      s1_move;
    logic                      s2_last;
    logic                      out_load;
    logic [1:0]                sel;

    assign in_acc = i_in_valid & o_in_ready;
    assign cur_px = {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RGBU_WIDTH_RST;
            r_cfg_height <= RGBU_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[RGBU_WREG_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp the image size to the supported range
    always_comb begin
        wreg_ext = WW'(r_cfg_width);
        if (wreg_ext == '0) begin
            w_eff = WW'(1);
        end else if (wreg_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = wreg_ext;
        end
        if (r_cfg_height == '0) begin
            h_eff = RGBU_HREG_W'(1);
        end else if (r_cfg_height > RGBU_HREG_W'(RGBU_MAX_HEIGHT)) begin
            h_eff = RGBU_HREG_W'(RGBU_MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_height;
        end
    end

    // Position of the current pixel and the counters after it
    always_comb begin
        pre_wrap = WW'(r_col) >= w_eff;
        cur_j    = pre_wrap ? '0 : r_col;
        row_pre  = pre_wrap ? ({1'b0, r_row} + RGBU_HREG_W'(1)) : {1'b0, r_row};
        cur_i    = (row_pre >= h_eff) ? '0 : row_pre[RGBU_ROW_W-1:0];
        j_inc    = WW'(cur_j) + WW'(1);
        i_inc    = {1'b0, cur_i} + RGBU_HREG_W'(1);
        c2_full  = {cur_j, 1'b0};
        if (j_inc >= w_eff) begin
            n_col = '0;
            n_row = (i_inc >= h_eff) ? '0 : i_inc[RGBU_ROW_W-1:0];
        end else begin
            n_col = j_inc[CW-1:0];
            n_row = cur_i;
        end
    end

    // Advance the counters and hold the left neighbour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_left <= cur_px;
        end
    end

    // Line buffer: read the pixel above and overwrite it with the current one
    rgbu_ram #(
        .WIDTH (RGBU_PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (cur_j),
        .i_wdata (cur_px),
        .i_re    (in_acc),
        .i_raddr (cur_j),
        .o_rdata (ram_rdata)
    );

    // Handshake between stages
    assign out_load   = (r_s2_mask != '0) & (~r_out_valid | i_out_ready);
    assign s2_last    = (r_s2_mask & (r_s2_mask - 4'd1)) == '0;
    assign s1_move    = r_s1_valid & ((r_s2_mask == '0) | (out_load & s2_last));
    assign o_in_ready = ~r_s1_valid | s1_move;

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cur  <= cur_px;
            r_s1_left <= r_left;
            r_s1_r2   <= {cur_i, 1'b0};
            r_s1_c2   <= RGBU_OUT_COL_W'(c2_full);
            r_s1_top  <= cur_i != '0;
            r_s1_mid  <= cur_j != '0;
        end
    end

    assign vavg = avg24(ram_rdata, r_s1_cur);

    // Keep the vertical average of the previous column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lva <= '0;
        end else if (s1_move && r_s1_top) begin
            r_lva <= vavg;
        end
    end

    // Stage 2 slot mask: load a fresh set or drop the slot just sent
    always_comb begin
        n_s2_mask = r_s2_mask;
        if (s1_move) begin
            n_s2_mask = {1'b1, r_s1_mid, r_s1_top, r_s1_top & r_s1_mid};
        end else if (out_load) begin
            n_s2_mask = r_s2_mask & (r_s2_mask - 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= '0;
        end else begin
            r_s2_mask <= n_s2_mask;
        end
    end

    // Stage 2 result pixels
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_px[0] <= avg24(r_lva, vavg);
            r_s2_px[1] <= vavg;
            r_s2_px[2] <= avg24(r_s1_left, r_s1_cur);
            r_s2_px[3] <= r_s1_cur;
            r_s2_r2    <= r_s1_r2;
            r_s2_c2    <= r_s1_c2;
        end
    end

    // Pick the lowest pending slot
    always_comb begin
        if (r_s2_mask[0]) begin
            sel = 2'd0;
        end else if (r_s2_mask[1]) begin
            sel = 2'd1;
        end else if (r_s2_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.out_blue    <= r_s2_px[sel][7:0];
            r_out.out_green   <= r_s2_px[sel][15:8];
            r_out.out_red     <= r_s2_px[sel][23:16];
            r_out.out_row     <= sel[1] ? r_s2_r2 : (r_s2_r2 - RGBU_OUT_ROW_W'(1));
            r_out.out_col     <= sel[0] ? r_s2_c2 : (r_s2_c2 - RGBU_OUT_COL_W'(1));
            r_out.last_of_run <= s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Column counter stays in range after every pixel taken with no cfg write
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_we) |=> (WW'(r_col) < w_eff))
        else $error("column counter left the row");

    // The original pixel is always the last slot to drain
    a_orig_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_mask != '0) |-> r_s2_mask[3])
        else $error("result slots lost the original pixel");

    // A result marked last empties the sequencer unless a new pixel moves in
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && s2_last && !s1_move) |=> (r_s2_mask == '0))
        else $error("sequencer not empty after last result");

    // Nothing is offered in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

### hw/rtl/rgbu_ram.sv
// ----------------------------------------------------------------------------
// rgbu_ram: generic simple dual-port RAM
// One write port and one read port, registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module rgbu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read data when asked
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb_rgb_2x_average_upscaler_top.sv
// ----------------------------------------------------------------------------
// tb_rgb_2x_average_upscaler_top: self-checking bench of the 2x upscaler
// Streams source pixels through the valid/ready input under random bursts,
// predicts every enlarged-image pixel with an independent line-buffer model
// and compares each result field by field while the receiver stalls at will.
// Covers small frames, mid-frame register writes, zero and saturated sizes.
// ----------------------------------------------------------------------------
module tb_rgb_2x_average_upscaler_top;
    import rgbu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 120;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_PERIODIC
    } t_stall_mode;

    // Block ports
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    t_pix_in                    i_in_data  = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    t_pix_out                   o_out_data;
    logic                       i_cfg_we   = 1'b0;
    t_cfg_idx                   i_cfg_idx  = CFG_IMAGE_WIDTH;
    logic [RGBU_CFG_DATA_W-1:0] i_cfg_data = '0;

    // Stimulus and expectations
    t_pix_in     source_pixels[$];
    t_pix_out    expected_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Shadow of the block: registers, line buffer, held neighbours, position
    logic [RGBU_WREG_W-1:0] shadow_width  = RGBU_WIDTH_RST;
    logic [RGBU_HREG_W-1:0] shadow_height = RGBU_HEIGHT_RST;
    t_pix_in                line_store [RGBU_MAX_WIDTH];
    t_pix_in                left_source   = '0;
    t_pix_in                left_vertical = '0;
    int unsigned            col_pos = 0;
    int unsigned            row_pos = 0;

    // Sender and receiver pacing
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_span = 0;
    t_stall_mode stall_mode = READY_ALWAYS;

    rgb_2x_average_upscaler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Clamp register values to the sizes the block works with
    function automatic int unsigned eff_width(logic [RGBU_WREG_W-1:0] r);
        if (r == 0) return 1;
        if (r > RGBU_MAX_WIDTH) return RGBU_MAX_WIDTH;
        return 32'(r);
    endfunction

    function automatic int unsigned eff_height(logic [RGBU_HREG_W-1:0] r);
        if (r == 0) return 1;
        if (r > RGBU_MAX_HEIGHT) return RGBU_MAX_HEIGHT;
        return 32'(r);
    endfunction

    function automatic logic [7:0] byte_mean(logic [7:0] x, logic [7:0] y);
        logic [8:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[8:1];
    endfunction

    function automatic t_pix_in mean_pix(t_pix_in a, t_pix_in b);
        t_pix_in m;
        m.in_blue  = byte_mean(a.in_blue, b.in_blue);
        m.in_green = byte_mean(a.in_green, b.in_green);
        m.in_red   = byte_mean(a.in_red, b.in_red);
        return m;
    endfunction

    function automatic t_pix_out make_result(t_pix_in p, int unsigned row,
                                             int unsigned col, logic last);
        t_pix_out r;
        r.out_blue    = p.in_blue;
        r.out_green   = p.in_green;
        r.out_red     = p.in_red;
        r.out_row     = row[RGBU_OUT_ROW_W-1:0];
        r.out_col     = col[RGBU_OUT_COL_W-1:0];
        r.last_of_run = last;
        return r;
    endfunction

    // Work out the enlarged-image pixels caused by one accepted source pixel
    function automatic void predict_upscaled(t_pix_in px);
        int unsigned w;
        int unsigned h;
        int unsigned r2;
        int unsigned c2;
        t_pix_in     vavg;
        w = eff_width(shadow_width);
        h = eff_height(shadow_height);
        // advance past a row the registers have since made shorter
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r2 = 2 * row_pos;
        c2 = 2 * col_pos;
        if (row_pos > 0) begin
            vavg = mean_pix(line_store[col_pos], px);
            if (col_pos > 0)
                expected_pixels.push_back(
                    make_result(mean_pix(left_vertical, vavg), r2 - 1, c2 - 1, 1'b0));
            expected_pixels.push_back(make_result(vavg, r2 - 1, c2, 1'b0));
            left_vertical = vavg;
        end
        if (col_pos > 0)
            expected_pixels.push_back(
                make_result(mean_pix(left_source, px), r2, c2 - 1, 1'b0));
        expected_pixels.push_back(make_result(px, r2, c2, 1'b1));
        left_source         = px;
        line_store[col_pos] = px;
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h01;
            3: return 8'hFE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pix_in random_pixel();
        t_pix_in p;
        p.in_blue  = random_byte();
        p.in_green = random_byte();
        p.in_red   = random_byte();
        return p;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want,
                                          logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Write one register; the shadow follows at the write edge
    task automatic write_register(t_cfg_idx idx, logic [RGBU_CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) shadow_width = value[RGBU_WREG_W-1:0];
        else shadow_height = value;
    endtask

    // Hold until every pixel is sent and every result has come back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (source_pixels.size() != 0 || i_in_valid || expected_pixels.size() != 0);
    endtask

    // Sender: launch queued pixels in bursts with random gaps between them
    always @(posedge i_clk) begin : drive_source
        logic    next_valid;
        t_pix_in next_data;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            next_valid = i_in_valid;
            next_data  = i_in_data;
            if (i_in_valid && o_in_ready) begin
                predict_upscaled(i_in_data);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (source_pixels.size() != 0) begin
                    next_data  = source_pixels.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            i_in_valid <= next_valid;
            i_in_data  <= next_data;
        end
    end

    // Receiver: check each accepted item, then pick the next ready level
    always @(posedge i_clk) begin : watch_results
        t_pix_out want;
        logic     next_ready;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_out_data);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    compare_field("out_blue", 16'(want.out_blue),
                                  16'(o_out_data.out_blue));
                    compare_field("out_green", 16'(want.out_green),
                                  16'(o_out_data.out_green));
                    compare_field("out_red", 16'(want.out_red),
                                  16'(o_out_data.out_red));
                    compare_field("out_row", 16'(want.out_row),
                                  16'(o_out_data.out_row));
                    compare_field("out_col", 16'(want.out_col),
                                  16'(o_out_data.out_col));
                    compare_field("last_of_run", 16'(want.last_of_run),
                                  16'(o_out_data.last_of_run));
                end
            end
            if (stall_span == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_span = $urandom_range(4, 40);
            end
            stall_span--;
            case (stall_mode)
                READY_ALWAYS: next_ready = 1'b1;
                READY_COIN:   next_ready = 1'($urandom_range(0, 1));
                READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
                default:      next_ready = (stall_span % 8) < 2;
            endcase
            i_out_ready <= next_ready;
        end
    end

    // Abort a run that has stopped making progress
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [23:0] corner_pixels [9];
        int unsigned random_sent;
        int unsigned burst_items;
        corner_pixels = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'h0180FE,
                          24'hFEFF01, 24'h010101, 24'h7F80FF, 24'hFFFFFF};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the first nine line buffer columns, one row only
        write_register(CFG_IMAGE_WIDTH, 13'd9);
        write_register(CFG_IMAGE_HEIGHT, 13'd1);
        repeat (9) source_pixels.push_back(random_pixel());
        wait_idle();

        // Full 3x3 frame: every kind of interpolated pixel, byte extremes
        write_register(CFG_IMAGE_WIDTH, 13'd3);
        write_register(CFG_IMAGE_HEIGHT, 13'd3);
        foreach (corner_pixels[k]) source_pixels.push_back(t_pix_in'(corner_pixels[k]));
        wait_idle();

        // Zero sizes act as one: each pixel is its own frame
        write_register(CFG_IMAGE_WIDTH, 13'd0);
        write_register(CFG_IMAGE_HEIGHT, 13'd0);
        source_pixels.push_back(t_pix_in'(24'h000000));
        source_pixels.push_back(t_pix_in'(24'hFFFFFF));
        source_pixels.push_back(t_pix_in'(24'h80807F));
        wait_idle();

        // Shrink both sizes mid-frame: skip to the next row, then wrap the frame
        write_register(CFG_IMAGE_WIDTH, 13'd4);
        write_register(CFG_IMAGE_HEIGHT, 13'd5);
        repeat (6) source_pixels.push_back(random_pixel());
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, 13'd2);
        write_register(CFG_IMAGE_HEIGHT, 13'd2);
        repeat (4) source_pixels.push_back(random_pixel());
        wait_idle();

        // Oversized width saturates: a short stretch of one long row
        write_register(CFG_IMAGE_WIDTH, 13'd4095);
        write_register(CFG_IMAGE_HEIGHT, 13'd1);
        repeat (5) source_pixels.push_back(random_pixel());
        wait_idle();

        // Oversized height saturates: a short one-pixel column down a tall frame
        write_register(CFG_IMAGE_WIDTH, 13'd1);
        write_register(CFG_IMAGE_HEIGHT, 13'd8191);
        repeat (5) source_pixels.push_back(random_pixel());
        wait_idle();

        // Random small frames, with register writes landing mid-frame
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_IMAGE_WIDTH, 13'($urandom_range(0, 9)));
            if ($urandom_range(0, 3) != 0)
                write_register(CFG_IMAGE_HEIGHT, ($urandom_range(0, 9) == 0) ?
                               13'($urandom_range(0, 8191)) : 13'($urandom_range(0, 6)));
            burst_items = $urandom_range(1, 30);
            repeat (burst_items) source_pixels.push_back(random_pixel());
            random_sent += burst_items;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
